// File: rtl/tsac_pkg.sv
// Shared types and constants of the turn signal and headlamp controller.
// No dependencies; every other file depends on this package.
package tsac_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int TIMER_BITS_DEF  = 32;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 3;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_LEFT_ZONE_MAX     = 3'd0,
		CFG_CENTER_ZONE_LOW   = 3'd1,
		CFG_CENTER_ZONE_HIGH  = 3'd2,
		CFG_RIGHT_ZONE_MIN    = 3'd3,
		CFG_LAMP_ON_LEVEL     = 3'd4,
		CFG_LAMP_OFF_LEVEL    = 3'd5,
		CFG_BLINK_HALF_PERIOD = 3'd6
	} cfg_idx_t;

	// Register values after reset.
	localparam int unsigned LEFT_ZONE_MAX_RST     = 32'd1433;
	localparam int unsigned CENTER_ZONE_LOW_RST   = 32'd1638;
	localparam int unsigned CENTER_ZONE_HIGH_RST  = 32'd2457;
	localparam int unsigned RIGHT_ZONE_MIN_RST    = 32'd2662;
	localparam int unsigned LAMP_ON_LEVEL_RST     = 32'd2048;
	localparam int unsigned LAMP_OFF_LEVEL_RST    = 32'd2300;
	localparam int unsigned BLINK_HALF_PERIOD_RST = 32'd50000000;

	typedef enum logic [1:0] {
		ZONE_LEFT   = 2'd0,
		ZONE_CENTER = 2'd1,
		ZONE_RIGHT  = 2'd2,
		ZONE_TRANS  = 2'd3
	} zone_t;

	typedef enum logic [1:0] {
		ARM_NONE  = 2'd0,
		ARM_LEFT  = 2'd1,
		ARM_RIGHT = 2'd2
	} turn_t;

	// What the front end learns about one item, apart from its timer value.
	typedef struct packed {
		zone_t zone;
		logic  lamp_on_hit;
		logic  lamp_off_hit;
		logic  left_level;
		logic  right_level;
	} class_t;

endpackage

// File: rtl/tsac_if.sv
// Valid/ready channels for input items and result items.
// Depends on tsac_pkg for default widths.
interface tsac_sample_if #(
	parameter int SAMPLE_BITS = tsac_pkg::SAMPLE_BITS_DEF,
	parameter int TIMER_BITS  = tsac_pkg::TIMER_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] steering_sample;
	logic [SAMPLE_BITS-1:0] light_sample;
	logic                   left_lever_level;
	logic                   right_lever_level;
	logic [TIMER_BITS-1:0]  timer_now;

	modport source (
		output valid, steering_sample, light_sample, left_lever_level,
		       right_lever_level, timer_now,
		input  ready
	);
	modport sink (
		input  valid, steering_sample, light_sample, left_lever_level,
		       right_lever_level, timer_now,
		output ready
	);
endinterface

interface tsac_result_if;
	logic       valid;
	logic       ready;
	logic       left_lamp;
	logic       right_lamp;
	logic       wrong_way_alarm;
	logic       headlamp;
	logic [1:0] turn_mode;
	logic       blink_phase;

	modport source (
		output valid, left_lamp, right_lamp, wrong_way_alarm, headlamp, turn_mode,
		       blink_phase,
		input  ready
	);
	modport sink (
		input  valid, left_lamp, right_lamp, wrong_way_alarm, headlamp, turn_mode,
		       blink_phase,
		output ready
	);
endinterface

// File: rtl/tsac_front.sv
// Front end: accepts input items, sorts the steering sample into a zone and
// compares the light sample against the lamp levels. Depends on tsac_pkg, tsac_if.
module tsac_front #(
	parameter int SAMPLE_BITS = tsac_pkg::SAMPLE_BITS_DEF,
	parameter int TIMER_BITS  = tsac_pkg::TIMER_BITS_DEF
) (
	tsac_sample_if.sink              samples,
	input  logic [SAMPLE_BITS-1:0]   left_zone_max,
	input  logic [SAMPLE_BITS-1:0]   center_zone_low,
	input  logic [SAMPLE_BITS-1:0]   center_zone_high,
	input  logic [SAMPLE_BITS-1:0]   right_zone_min,
	input  logic [SAMPLE_BITS-1:0]   lamp_on_level,
	input  logic [SAMPLE_BITS-1:0]   lamp_off_level,
	output logic                     push_valid,
	input  logic                     push_ready,
	output tsac_pkg::class_t         push_class,
	output logic [TIMER_BITS-1:0]    push_now
);
	import tsac_pkg::*;

	zone_t zone;

	// Left wins over right, right over center, when zones overlap.
	always_comb begin
		if (samples.steering_sample <= left_zone_max) begin
			zone = ZONE_LEFT;
		end else if (samples.steering_sample >= right_zone_min) begin
			zone = ZONE_RIGHT;
		end else if (samples.steering_sample >= center_zone_low &&
		             samples.steering_sample <= center_zone_high) begin
			zone = ZONE_CENTER;
		end else begin
			zone = ZONE_TRANS;
		end
	end

	always_comb begin
		push_class.zone         = zone;
		push_class.lamp_on_hit  = samples.light_sample <= lamp_on_level;
		push_class.lamp_off_hit = samples.light_sample >= lamp_off_level;
		push_class.left_level   = samples.left_lever_level;
		push_class.right_level  = samples.right_lever_level;
	end

	assign push_now      = samples.timer_now;
	assign push_valid    = samples.valid;
	assign samples.ready = push_ready;

endmodule

// File: rtl/tsac_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on tsac_pkg only for the common import convention.
module tsac_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import tsac_pkg::*;

	localparam int DEPTH = 2;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != 2'(DEPTH);
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/tsac_back.sv
// Back end: lever edges, turn arming and cancel, headlamp hysteresis, blink
// timing and the result register. Depends on tsac_pkg, tsac_if.
module tsac_back #(
	parameter int TIMER_BITS = tsac_pkg::TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  tsac_pkg::class_t      pop_class,
	input  logic [TIMER_BITS-1:0] pop_now,
	input  logic [TIMER_BITS-1:0] blink_half_period,
	tsac_result_if.source         results
);
	import tsac_pkg::*;

	turn_t                 armed_q;
	logic                  left_reached_q;
	logic                  right_reached_q;
	logic                  prev_left_q;
	logic                  prev_right_q;
	logic                  blink_q;
	logic                  lamp_q;
	logic [TIMER_BITS-1:0] stamp_q;

	logic                  out_valid_q;
	logic                  out_left_q;
	logic                  out_right_q;
	logic                  out_alarm_q;
	logic                  out_lamp_q;
	turn_t                 out_turn_q;
	logic                  out_blink_q;

	logic                  fire;
	logic                  edge_left;
	logic                  edge_right;
	logic                  lamp_n;
	turn_t                 armed_a;
	turn_t                 armed_n;
	logic                  left_reached_n;
	logic                  right_reached_n;
	logic                  blink_a;
	logic                  blink_n;
	logic                  cancel;
	logic                  alarm;
	logic                  toggle;
	logic [TIMER_BITS-1:0] stamp_a;
	logic [TIMER_BITS-1:0] stamp_n;
	logic [TIMER_BITS-1:0] elapsed;

	assign pop_ready = !out_valid_q || results.ready;
	assign fire      = pop_valid && pop_ready;

	always_comb begin
		if (!lamp_q && pop_class.lamp_on_hit) begin
			lamp_n = 1'b1;
		end else if (lamp_q && pop_class.lamp_off_hit) begin
			lamp_n = 1'b0;
		end else begin
			lamp_n = lamp_q;
		end

		// The left lever is checked first; a right edge in the same item is lost.
		edge_left  = prev_left_q && !pop_class.left_level;
		edge_right = !edge_left && prev_right_q && !pop_class.right_level;

		armed_a         = armed_q;
		left_reached_n  = left_reached_q;
		right_reached_n = right_reached_q;
		blink_a         = blink_q;
		stamp_a         = stamp_q;
		if (edge_left || edge_right) begin
			armed_a         = edge_left ? ARM_LEFT : ARM_RIGHT;
			left_reached_n  = 1'b0;
			right_reached_n = 1'b0;
			blink_a         = 1'b1;
			stamp_a         = pop_now;
		end

		if (armed_a == ARM_LEFT && pop_class.zone == ZONE_LEFT) begin
			left_reached_n = 1'b1;
		end else if (armed_a == ARM_RIGHT && pop_class.zone == ZONE_RIGHT) begin
			right_reached_n = 1'b1;
		end

		cancel = pop_class.zone == ZONE_CENTER &&
		         ((armed_a == ARM_LEFT && left_reached_n) ||
		          (armed_a == ARM_RIGHT && right_reached_n));
		armed_n = cancel ? ARM_NONE : armed_a;
		blink_n = cancel ? 1'b0 : blink_a;

		alarm = (armed_n == ARM_LEFT && pop_class.zone == ZONE_RIGHT) ||
		        (armed_n == ARM_RIGHT && pop_class.zone == ZONE_LEFT);

		// Wrapping difference; it is zero right after a lever edge stamps the time.
		elapsed = pop_now - stamp_a;
		toggle  = armed_n != ARM_NONE && elapsed >= blink_half_period;
		stamp_n = toggle ? pop_now : stamp_a;
		if (toggle) begin
			blink_n = ~blink_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q         <= ARM_NONE;
			left_reached_q  <= 1'b0;
			right_reached_q <= 1'b0;
			prev_left_q     <= 1'b1;
			prev_right_q    <= 1'b1;
			blink_q         <= 1'b0;
			lamp_q          <= 1'b0;
			stamp_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (fire) begin
				armed_q         <= armed_n;
				left_reached_q  <= left_reached_n;
				right_reached_q <= right_reached_n;
				prev_left_q     <= pop_class.left_level;
				prev_right_q    <= pop_class.right_level;
				blink_q         <= blink_n;
				lamp_q          <= lamp_n;
				stamp_q         <= stamp_n;
				out_valid_q     <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_left_q  <= (armed_n == ARM_LEFT) && blink_n;
			out_right_q <= (armed_n == ARM_RIGHT) && blink_n;
			out_alarm_q <= alarm;
			out_lamp_q  <= lamp_n;
			out_turn_q  <= armed_n;
			out_blink_q <= blink_n;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.left_lamp       = out_left_q;
	assign results.right_lamp      = out_right_q;
	assign results.wrong_way_alarm = out_alarm_q;
	assign results.headlamp        = out_lamp_q;
	assign results.turn_mode       = out_turn_q;
	assign results.blink_phase     = out_blink_q;

endmodule

// File: rtl/turn_signal_autolight_controller_top.sv
// Channel   Dir  Handshake     Payload
// samples   in   valid/ready   steering, light, two lever levels, timer value
// results   out  valid/ready   indicator lamps, alarm, headlamp, turn mode, blink phase
// cfg       in   cfg_we        cfg_index, cfg_wdata (no read-back)
//
// One item per clock is sustained while results are taken; an accepted item goes first into
// a queue slot and then into the back end state and the result register.
// The back end updates its state and the result register at the same clock edge.
// A stalled result holds the back end; the two-entry queue keeps taking items until full.
// Reset is asynchronous and active low; it loads the register defaults and resets the control state.
// Depends on tsac_pkg, tsac_if, tsac_front, tsac_queue and tsac_back.
module turn_signal_autolight_controller_top #(
	parameter int SAMPLE_BITS = tsac_pkg::SAMPLE_BITS_DEF,
	parameter int TIMER_BITS  = tsac_pkg::TIMER_BITS_DEF,
	parameter int CFG_BITS    = (TIMER_BITS > SAMPLE_BITS) ? TIMER_BITS : SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	tsac_sample_if.sink                       samples,
	tsac_result_if.source                     results,
	input  logic                              cfg_we,
	input  logic [tsac_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]               cfg_wdata
);
	import tsac_pkg::*;

	localparam int QUEUE_BITS = $bits(class_t) + TIMER_BITS;

	logic [SAMPLE_BITS-1:0] left_zone_max_q;
	logic [SAMPLE_BITS-1:0] center_zone_low_q;
	logic [SAMPLE_BITS-1:0] center_zone_high_q;
	logic [SAMPLE_BITS-1:0] right_zone_min_q;
	logic [SAMPLE_BITS-1:0] lamp_on_level_q;
	logic [SAMPLE_BITS-1:0] lamp_off_level_q;
	logic [TIMER_BITS-1:0]  blink_half_period_q;

	logic                  push_valid;
	logic                  push_ready;
	class_t                push_class;
	logic [TIMER_BITS-1:0] push_now;
	logic                  pop_valid;
	logic                  pop_ready;
	logic [QUEUE_BITS-1:0] pop_data;
	class_t                pop_class;
	logic [TIMER_BITS-1:0] pop_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_zone_max_q     <= SAMPLE_BITS'(LEFT_ZONE_MAX_RST);
			center_zone_low_q   <= SAMPLE_BITS'(CENTER_ZONE_LOW_RST);
			center_zone_high_q  <= SAMPLE_BITS'(CENTER_ZONE_HIGH_RST);
			right_zone_min_q    <= SAMPLE_BITS'(RIGHT_ZONE_MIN_RST);
			lamp_on_level_q     <= SAMPLE_BITS'(LAMP_ON_LEVEL_RST);
			lamp_off_level_q    <= SAMPLE_BITS'(LAMP_OFF_LEVEL_RST);
			blink_half_period_q <= TIMER_BITS'(BLINK_HALF_PERIOD_RST);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LEFT_ZONE_MAX:     left_zone_max_q     <= cfg_wdata[SAMPLE_BITS-1:0];
				CFG_CENTER_ZONE_LOW:   center_zone_low_q   <= cfg_wdata[SAMPLE_BITS-1:0];
				CFG_CENTER_ZONE_HIGH:  center_zone_high_q  <= cfg_wdata[SAMPLE_BITS-1:0];
				CFG_RIGHT_ZONE_MIN:    right_zone_min_q    <= cfg_wdata[SAMPLE_BITS-1:0];
				CFG_LAMP_ON_LEVEL:     lamp_on_level_q     <= cfg_wdata[SAMPLE_BITS-1:0];
				CFG_LAMP_OFF_LEVEL:    lamp_off_level_q    <= cfg_wdata[SAMPLE_BITS-1:0];
				CFG_BLINK_HALF_PERIOD: blink_half_period_q <= cfg_wdata[TIMER_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	tsac_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.TIMER_BITS  (TIMER_BITS)
	) u_front (
		.samples          (samples),
		.left_zone_max    (left_zone_max_q),
		.center_zone_low  (center_zone_low_q),
		.center_zone_high (center_zone_high_q),
		.right_zone_min   (right_zone_min_q),
		.lamp_on_level    (lamp_on_level_q),
		.lamp_off_level   (lamp_off_level_q),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_class       (push_class),
		.push_now         (push_now)
	);

	tsac_queue #(
		.WIDTH (QUEUE_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_class, push_now}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_class = class_t'(pop_data[QUEUE_BITS-1:TIMER_BITS]);
	assign pop_now   = pop_data[TIMER_BITS-1:0];

	tsac_back #(
		.TIMER_BITS (TIMER_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.pop_valid         (pop_valid),
		.pop_ready         (pop_ready),
		.pop_class         (pop_class),
		.pop_now           (pop_now),
		.blink_half_period (blink_half_period_q),
		.results           (results)
	);

	// Only one indicator can be lit at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !(results.left_lamp && results.right_lamp))
		else $error("both indicators lit");

	// A lit left indicator follows the blink phase of an armed left turn.
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.left_lamp) |->
		(results.blink_phase && results.turn_mode == ARM_LEFT))
		else $error("left indicator lit without a left turn in phase");

	// The alarm needs an armed turn.
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.wrong_way_alarm) |-> results.turn_mode != ARM_NONE)
		else $error("alarm without an armed turn");

	// With no turn armed the blink phase rests low.
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.turn_mode == ARM_NONE) |-> !results.blink_phase)
		else $error("blink phase high with no turn armed");

endmodule
